// ===== rtl/bmcd_pkg.sv =====
`default_nettype none
package bmcd_pkg;

	localparam int TicksW = 16;

	// input item and result item
	typedef struct packed {
		logic kind;
		logic pressed;
	} in_t;

	typedef struct packed {
		logic [2:0] event_code;
		logic       last;
	} out_t;

	// events produced by one tick, in order
	typedef struct packed {
		logic [1:0] num;
		logic [2:0] code0;
		logic [2:0] code1;
	} ev_pair_t;

	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_RESET = 1'b1;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_PRESSED1 = 3'd1;
	localparam logic [2:0] ST_PAUSE1   = 3'd2;
	localparam logic [2:0] ST_PRESSED2 = 3'd3;
	localparam logic [2:0] ST_PAUSE2   = 3'd4;
	localparam logic [2:0] ST_PRESSED3 = 3'd5;
	localparam logic [2:0] ST_LONG     = 3'd6;

	localparam logic [2:0] EV_SINGLE   = 3'd0;
	localparam logic [2:0] EV_DOUBLE   = 3'd1;
	localparam logic [2:0] EV_TRIPLE   = 3'd2;
	localparam logic [2:0] EV_PRESSED  = 3'd3;
	localparam logic [2:0] EV_RELEASED = 3'd4;
	localparam logic [2:0] EV_TRIGGER  = 3'd5;
	localparam logic [2:0] EV_ON       = 3'd6;
	localparam logic [2:0] EV_OFF      = 3'd7;

	localparam logic [2:0] MODE_FRONT  = 3'd0;
	localparam logic [2:0] MODE_SINGLE = 3'd1;
	localparam logic [2:0] MODE_DOUBLE = 3'd2;
	localparam logic [2:0] MODE_TRIPLE = 3'd3;
	localparam logic [2:0] MODE_LONG   = 3'd4;

	localparam logic [1:0] TYPE_TOGGLE    = 2'd0;
	localparam logic [1:0] TYPE_MOMENTARY = 2'd1;
	localparam logic [1:0] TYPE_MULTI     = 2'd2;

	localparam logic [1:0] REG_SWITCH_TYPE = 2'd0;
	localparam logic [1:0] REG_SWITCH_MODE = 2'd1;
	localparam logic [1:0] REG_MAX_PAUSE   = 2'd2;
	localparam logic [1:0] REG_LONG_PRESS  = 2'd3;

	localparam logic [TicksW-1:0] SETTLE_TICKS    = 16'd2;
	localparam logic [TicksW-1:0] TICKS_MAX       = 16'hFFFF;
	localparam logic [TicksW-1:0] MAX_PAUSE_RST   = 16'd30;
	localparam logic [TicksW-1:0] LONG_PRESS_RST  = 16'd100;

	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);

endpackage
`default_nettype wire

// ===== rtl/button_multi_click_detector.sv =====
`default_nettype none
// An accepted item is registered in the input stage, evaluated by the core, and its events are
// written into the event queue, which presents them on the output.
// Throughput: one item per cycle while the queue has room; two events give two output items.
// The four-entry event queue sets the stall point: input stalls when fewer than two are free.
// Reset: asynchronous, active low; config registers return to their defaults, state to idle.
module button_multi_click_detector import bmcd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire in_t               in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output out_t                   out_data,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [TicksW-1:0] cfg_data
);

	logic     valid_s1;
	in_t      item_s1;
	logic     room;
	logic     step;
	ev_pair_t events;

	assign step     = valid_s1 && room;
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	bmcd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.events    (events)
	);

	bmcd_evq u_evq (
		.clk       (clk),
		.arst_n    (arst_n),
		.events    (events),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== rtl/bmcd_core.sv =====
`default_nettype none
module bmcd_core import bmcd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire in_t               item,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [TicksW-1:0] cfg_data,
	output ev_pair_t               events
);

	logic [1:0]        switch_type_q;
	logic [2:0]        switch_mode_q;
	logic [TicksW-1:0] max_pause_q;
	logic [TicksW-1:0] long_press_q;
	logic [2:0]        state_q;
	logic [TicksW-1:0] ticks_q;

	logic [TicksW-1:0] ticks_inc;
	logic [2:0]        state_d;
	logic              change;
	logic              p;

	assign p         = item.pressed;
	assign ticks_inc = (ticks_q == TICKS_MAX) ? ticks_q : ticks_q + TicksW'(1);

	always_comb begin
		state_d      = state_q;
		change       = 1'b0;
		events.num   = 2'd0;
		events.code0 = EV_SINGLE;
		events.code1 = EV_TRIGGER;
		if (item.kind == KIND_TICK && ticks_inc >= SETTLE_TICKS) begin
			case (switch_type_q)
				TYPE_TOGGLE: begin
					if (state_q == ST_IDLE) begin
						if (p) begin
							state_d      = ST_PRESSED1;
							change       = 1'b1;
							events.code0 = EV_SINGLE;
							events.code1 = EV_TRIGGER;
							events.num   = (switch_mode_q == MODE_FRONT) ? 2'd2 : 2'd1;
						end
					end else if (state_q == ST_PRESSED1) begin
						if (!p) begin
							state_d = ST_IDLE;
							change  = 1'b1;
						end
					end else begin
						state_d = ST_IDLE;
						change  = 1'b1;
					end
				end
				TYPE_MOMENTARY: begin
					if (state_q == ST_IDLE) begin
						if (p) begin
							state_d      = ST_PRESSED1;
							change       = 1'b1;
							events.code0 = EV_PRESSED;
							events.code1 = EV_ON;
							events.num   = (switch_mode_q == MODE_FRONT) ? 2'd2 : 2'd1;
						end
					end else if (state_q == ST_PRESSED1) begin
						if (!p) begin
							state_d      = ST_IDLE;
							change       = 1'b1;
							events.code0 = EV_RELEASED;
							events.code1 = EV_OFF;
							events.num   = (switch_mode_q == MODE_FRONT) ? 2'd2 : 2'd1;
						end
					end else begin
						state_d = ST_IDLE;
						change  = 1'b1;
					end
				end
				TYPE_MULTI: begin
					case (state_q)
						ST_IDLE: begin
							if (p) begin
								state_d      = ST_PRESSED1;
								change       = 1'b1;
								events.code0 = EV_TRIGGER;
								events.num   = (switch_mode_q == MODE_FRONT) ? 2'd1 : 2'd0;
							end
						end
						ST_PRESSED1: begin
							if (p && ticks_inc > long_press_q) begin
								state_d      = ST_LONG;
								change       = 1'b1;
								events.code0 = EV_PRESSED;
								events.code1 = EV_TRIGGER;
								events.num   = (switch_mode_q == MODE_LONG) ? 2'd2 : 2'd1;
							end else if (!p) begin
								state_d = ST_PAUSE1;
								change  = 1'b1;
							end
						end
						ST_PAUSE1: begin
							if (!p && ticks_inc > max_pause_q) begin
								state_d      = ST_IDLE;
								change       = 1'b1;
								events.code0 = EV_SINGLE;
								events.code1 = EV_TRIGGER;
								events.num   = (switch_mode_q == MODE_SINGLE) ? 2'd2 : 2'd1;
							end else if (p) begin
								state_d = ST_PRESSED2;
								change  = 1'b1;
							end
						end
						ST_PRESSED2: begin
							if (!p) begin
								state_d = ST_PAUSE2;
								change  = 1'b1;
							end
						end
						ST_PAUSE2: begin
							if (!p && ticks_inc > max_pause_q) begin
								state_d      = ST_IDLE;
								change       = 1'b1;
								events.code0 = EV_DOUBLE;
								events.code1 = EV_TRIGGER;
								events.num   = (switch_mode_q == MODE_DOUBLE) ? 2'd2 : 2'd1;
							end else if (p) begin
								state_d = ST_PRESSED3;
								change  = 1'b1;
							end
						end
						ST_PRESSED3: begin
							if (!p) begin
								state_d = ST_IDLE;
								change  = 1'b1;
								// trigger goes ahead of the triple event
								if (switch_mode_q == MODE_TRIPLE) begin
									events.code0 = EV_TRIGGER;
									events.code1 = EV_TRIPLE;
									events.num   = 2'd2;
								end else begin
									events.code0 = EV_TRIPLE;
									events.num   = 2'd1;
								end
							end
						end
						ST_LONG: begin
							if (!p) begin
								state_d      = ST_IDLE;
								change       = 1'b1;
								events.code0 = EV_RELEASED;
								events.num   = 2'd1;
							end
						end
						default: begin
							state_d = state_q;
						end
					endcase
				end
				default: begin
					state_d = state_q;
				end
			endcase
		end
		if (!step) begin
			events.num = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_type_q <= TYPE_TOGGLE;
			switch_mode_q <= MODE_FRONT;
			max_pause_q   <= MAX_PAUSE_RST;
			long_press_q  <= LONG_PRESS_RST;
			state_q       <= ST_IDLE;
			ticks_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SWITCH_TYPE: switch_type_q <= cfg_data[1:0];
				REG_SWITCH_MODE: switch_mode_q <= cfg_data[2:0];
				REG_MAX_PAUSE:   max_pause_q   <= cfg_data;
				REG_LONG_PRESS:  long_press_q  <= cfg_data;
				default:         switch_type_q <= switch_type_q;
			endcase
			state_q <= ST_IDLE;
			ticks_q <= '0;
		end else if (step) begin
			if (item.kind == KIND_RESET) begin
				state_q <= ST_IDLE;
				ticks_q <= '0;
			end else begin
				state_q <= state_d;
				ticks_q <= change ? '0 : ticks_inc;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bmcd_evq.sv =====
`default_nettype none
module bmcd_evq import bmcd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ev_pair_t events,
	output logic          room,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_t          out_data
);

	out_t              mem_q [QDepth];
	logic [QPtrW-1:0]  head_q;
	logic [QPtrW-1:0]  tail_q;
	logic [QPtrW:0]    count_q;
	logic              pop;
	out_t              ent0;
	out_t              ent1;

	assign room      = count_q <= (QPtrW+1)'(QDepth - 2);
	assign out_valid = count_q != '0;
	assign out_data  = mem_q[head_q];
	assign pop       = out_valid && out_ready;

	assign ent0.event_code = events.code0;
	assign ent0.last       = events.num == 2'd1;
	assign ent1.event_code = events.code1;
	assign ent1.last       = 1'b1;

	always_ff @(posedge clk) begin
		if (events.num != 2'd0) begin
			mem_q[tail_q] <= ent0;
		end
		if (events.num == 2'd2) begin
			mem_q[tail_q + QPtrW'(1)] <= ent1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + QPtrW'(1);
			end
			tail_q  <= tail_q + QPtrW'(events.num);
			count_q <= count_q + (QPtrW+1)'(events.num) - (QPtrW+1)'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== tb/bmcd_event_checker.sv =====
`default_nettype none
module bmcd_event_checker import bmcd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_ready,
	input  wire in_t               in_data,
	input  wire logic              out_valid,
	input  wire logic              out_ready,
	input  wire out_t              out_data,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [TicksW-1:0] cfg_data,
	output int                     fail_count,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [1:0]        sw_type;
	logic [2:0]        sw_mode;
	logic [TicksW-1:0] pause_lim;
	logic [TicksW-1:0] long_lim;
	logic [2:0]        btn_state;
	logic [TicksW-1:0] held_ticks;
	out_t              event_queue [$];
	logic [2:0]        tick_events [$];
	out_t              want;
	int                errs;

	task automatic enter(input logic [2:0] next);
		btn_state = next;
		held_ticks = '0;
	endtask

	task automatic note(input logic [2:0] code);
		tick_events.push_back(code);
	endtask

	task automatic predict_events(input in_t item);
		out_t ev;
		logic p;
		logic toggle;
		p = item.pressed;
		tick_events.delete();
		if (item.kind == KIND_RESET) begin
			enter(ST_IDLE);
			return;
		end
		if (held_ticks != TICKS_MAX)
			held_ticks++;
		// nothing is decided until the state has settled
		if (held_ticks < SETTLE_TICKS)
			return;
		toggle = (sw_type == TYPE_TOGGLE);
		if (sw_type == TYPE_TOGGLE || sw_type == TYPE_MOMENTARY) begin
			if (btn_state == ST_IDLE) begin
				if (p) begin
					enter(ST_PRESSED1);
					note(toggle ? EV_SINGLE : EV_PRESSED);
					if (sw_mode == MODE_FRONT)
						note(toggle ? EV_TRIGGER : EV_ON);
				end
			end else if (btn_state == ST_PRESSED1) begin
				if (!p) begin
					enter(ST_IDLE);
					if (!toggle) begin
						note(EV_RELEASED);
						if (sw_mode == MODE_FRONT)
							note(EV_OFF);
					end
				end
			end else begin
				enter(ST_IDLE);
			end
		end else if (sw_type == TYPE_MULTI) begin
			case (btn_state)
			ST_IDLE: begin
				if (p) begin
					enter(ST_PRESSED1);
					if (sw_mode == MODE_FRONT)
						note(EV_TRIGGER);
				end
			end
			ST_PRESSED1: begin
				if (p && held_ticks > long_lim) begin
					enter(ST_LONG);
					note(EV_PRESSED);
					if (sw_mode == MODE_LONG)
						note(EV_TRIGGER);
				end else if (!p) begin
					enter(ST_PAUSE1);
				end
			end
			ST_PAUSE1: begin
				if (!p && held_ticks > pause_lim) begin
					enter(ST_IDLE);
					note(EV_SINGLE);
					if (sw_mode == MODE_SINGLE)
						note(EV_TRIGGER);
				end else if (p) begin
					enter(ST_PRESSED2);
				end
			end
			ST_PRESSED2: begin
				if (!p)
					enter(ST_PAUSE2);
			end
			ST_PAUSE2: begin
				if (!p && held_ticks > pause_lim) begin
					enter(ST_IDLE);
					note(EV_DOUBLE);
					if (sw_mode == MODE_DOUBLE)
						note(EV_TRIGGER);
				end else if (p) begin
					enter(ST_PRESSED3);
				end
			end
			ST_PRESSED3: begin
				// trigger goes out ahead of the triple event
				if (!p) begin
					enter(ST_IDLE);
					if (sw_mode == MODE_TRIPLE)
						note(EV_TRIGGER);
					note(EV_TRIPLE);
				end
			end
			ST_LONG: begin
				if (!p) begin
					enter(ST_IDLE);
					note(EV_RELEASED);
				end
			end
			default: ;
			endcase
		end
		foreach (tick_events[i]) begin
			ev.event_code = tick_events[i];
			ev.last = (i == tick_events.size() - 1);
			event_queue.push_back(ev);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_type = TYPE_TOGGLE;
			sw_mode = MODE_FRONT;
			pause_lim = MAX_PAUSE_RST;
			long_lim = LONG_PRESS_RST;
			btn_state = ST_IDLE;
			held_ticks = '0;
			event_queue.delete();
			errs = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_SWITCH_TYPE: sw_type = cfg_data[1:0];
				REG_SWITCH_MODE: sw_mode = cfg_data[2:0];
				REG_MAX_PAUSE:   pause_lim = cfg_data;
				REG_LONG_PRESS:  long_lim = cfg_data;
				endcase
				enter(ST_IDLE);
			end
			if (in_valid && in_ready)
				predict_events(in_data);
			if (out_valid && out_ready) begin
				if (event_queue.size() == 0) begin
					$error("unexpected event: event_code %0d last %0d",
						out_data.event_code, out_data.last);
					errs++;
				end else begin
					want = event_queue.pop_front();
					if (out_data.event_code !== want.event_code) begin
						$error("event_code: expected %0d, got %0d",
							want.event_code, out_data.event_code);
						errs++;
					end
					if (out_data.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, out_data.last);
						errs++;
					end
				end
			end
			fail_count <= errs;
			pending <= event_queue.size();
		end
	end

endmodule
`default_nettype wire

// ===== tb/button_multi_click_detector_tb.sv =====
`default_nettype none
module button_multi_click_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bmcd_pkg::*;

	localparam logic [1:0] TYPE_UNUSED = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	in_t               in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_t              out_data;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = REG_SWITCH_TYPE;
	logic [TicksW-1:0] cfg_data = '0;
	int                fail_count;
	int                pending;
	int                sent = 0;
	int                send_idle_pct = 23;
	int                recv_idle_pct = 76;
	logic [1:0]        cur_type = TYPE_TOGGLE;
	logic [TicksW-1:0] cur_pause = MAX_PAUSE_RST;
	logic [TicksW-1:0] cur_long = LONG_PRESS_RST;

	button_multi_click_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bmcd_event_checker watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	task automatic send_item(input in_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do
			@(posedge clk);
		while (!in_ready);
		sent++;
	endtask

	task automatic hold_level(input logic level, input int count);
		repeat (count) send_item('{kind: KIND_TICK, pressed: level});
	endtask

	// drop valid and wait until every expected event has been transferred
	task automatic wait_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(input logic [1:0] stype, input logic [2:0] smode,
			input logic [TicksW-1:0] pause, input logic [TicksW-1:0] hold);
		wait_quiet();
		cfg_we <= 1'b1;
		cfg_index <= REG_SWITCH_TYPE;
		cfg_data <= TicksW'(stype);
		@(posedge clk);
		cfg_index <= REG_SWITCH_MODE;
		cfg_data <= TicksW'(smode);
		@(posedge clk);
		cfg_index <= REG_MAX_PAUSE;
		cfg_data <= pause;
		@(posedge clk);
		cfg_index <= REG_LONG_PRESS;
		cfg_data <= hold;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_type = stype;
		cur_pause = pause;
		cur_long = hold;
	endtask

	function automatic logic [TicksW-1:0] pick_limit();
		case ($urandom_range(9))
		0: return '0;
		1: return TICKS_MAX;
		default: return TicksW'($urandom_range(12));
		endcase
	endfunction

	function automatic logic [1:0] pick_type();
		int r;
		r = $urandom_range(11);
		if (r == 0)
			return TYPE_UNUSED;
		else if (r < 3)
			return TYPE_TOGGLE;
		else if (r < 5)
			return TYPE_MOMENTARY;
		return TYPE_MULTI;
	endfunction

	// mostly press/release runs sized around the thresholds, some noise and resets
	task automatic random_batch(input int count);
		int stop_at;
		int pick;
		int span;
		logic level;
		stop_at = sent + count;
		level = 1'b0;
		while (sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 4) begin
				send_item('{kind: KIND_RESET, pressed: 1'($urandom_range(1))});
			end else if (pick < 12) begin
				send_item('{kind: KIND_TICK, pressed: 1'($urandom_range(1))});
			end else begin
				level = ~level;
				span = level ? int'(cur_long) : int'(cur_pause);
				if (cur_type != TYPE_MULTI || span > 40)
					span = 6;
				hold_level(level, $urandom_range(span + 4, 1));
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// out of reset: toggle with front trigger
		hold_level(1'b0, 1);
		hold_level(1'b1, 2);
		hold_level(1'b0, 2);
		send_item('{kind: KIND_RESET, pressed: 1'b1});

		write_config(TYPE_MOMENTARY, MODE_FRONT, MAX_PAUSE_RST, LONG_PRESS_RST);
		hold_level(1'b1, 2);
		hold_level(1'b0, 2);

		write_config(TYPE_MULTI, MODE_TRIPLE, TicksW'(2), TicksW'(4));
		repeat (3) begin
			hold_level(1'b1, 2);
			hold_level(1'b0, 2);
		end

		while (sent < 1600) begin
			if (sent < 580) begin
				send_idle_pct = 23;
				recv_idle_pct = 76;
			end else if (sent < 1140) begin
				send_idle_pct = 76;
				recv_idle_pct = 23;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_config(pick_type(), 3'($urandom_range(7)), pick_limit(), pick_limit());
			random_batch($urandom_range(80, 30));
		end

		in_valid <= 1'b0;
		@(posedge clk);
		for (int w = 0; w < 5000 && pending != 0; w++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("button_multi_click_detector regression: pass");
		else
			$display("button_multi_click_detector regression: fail");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("button_multi_click_detector regression: fail");
		$finish;
	end

endmodule
`default_nettype wire

// ===== button_multi_click_detector.f =====
rtl/bmcd_pkg.sv
rtl/bmcd_core.sv
rtl/bmcd_evq.sv
rtl/button_multi_click_detector.sv
tb/bmcd_event_checker.sv
tb/button_multi_click_detector_tb.sv
